[hdl/hse_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants for the histogram statistics engine
// Holds the request and result payload structures, operation codes and the
// sequencer state encoding.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int unsigned MAX_BINS_DEF = 4096;
  localparam logic [12:0] DEFAULT_BINS = 13'd256;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  localparam logic CFG_BINS  = 1'b0;
  localparam logic CFG_WIDTH = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sample;
  } req_t;

  typedef struct packed {
    logic        is_empty;
    logic [63:0] sample_total;
    logic [12:0] lowest_bin;
    logic [11:0] highest_bin;
    logic [11:0] mode_bin;
    logic [31:0] mode_count;
    logic [11:0] median_bin;
    logic [63:0] index_sum;
    logic [63:0] square_sum;
  } res_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_MUL,
    ST_M_RD,
    ST_M_ACC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

`default_nettype wire

[hdl/hse_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_divider: radix-2 restoring divider
// Produces a 32-bit quotient one bit a cycle.
// ----------------------------------------------------------------------------
module hse_divider
  import hse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output div_ctl_t         ctl,
  output logic [31:0]      quotient
);

  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dsr;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  always_comb begin
    trial = {rem, quo[31]} - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
      end else if (busy) begin
        // Shift one dividend bit into the remainder and keep the trial if it fits.
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign ctl.start = start;
  assign ctl.busy  = busy;
  assign ctl.done  = done;

endmodule

`default_nettype wire

[hdl/hse_bin_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hse_bin_ram: bin count storage
// Single port memory, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
module hse_bin_ram
  import hse_pkg::*;
#(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF,
  localparam int unsigned AW = $clog2(MAX_BINS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic [31:0]        rdata
);

  logic [31:0] mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[hdl/histogram_stats_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// histogram_stats_engine: histogram of 32-bit samples with statistics
// Sequenced engine with a divider, a bin memory and one multiplier.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake        | payload
//   req      | in        | req_valid/stall  | req_t  (op, sample)
//   res      | out       | res_valid/stall  | res_t  (query statistics)
//   cfg      | in        | cfg_we           | cfg_index, cfg_data
//
// An add runs the bit-serial divider to find its bin, then reads the bin count
// and writes it back plus one (the bin is left alone when it lies outside the
// active range). A query walks every active bin through the single memory port
// and the shared multiplier, then walks up to the median bin unless it is empty.
// A clear zeroes every bin, as does the pass after reset. Requests stall until idle.
// A waiting result does not hold off requests; a later query that finishes
// while it waits holds in its output state until the result is taken.
// ----------------------------------------------------------------------------
module histogram_stats_engine
  import hse_pkg::*;
#(
  parameter int unsigned MAX_BINS = MAX_BINS_DEF,
  localparam int unsigned AW = $clog2(MAX_BINS)
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             res_valid,
  input  wire logic        res_stall,
  output res_t             res,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [AW:0] NBINS = (AW+1)'(MAX_BINS);

  state_t      state, state_next;
  logic [12:0] bins_in_use;
  logic [31:0] bin_div;
  logic [AW:0] n_act;
  logic [AW:0] idx;
  logic [31:0] cnt;
  logic [63:0] total, wsum, sqsum, cum;
  logic [AW:0] lo;
  logic [AW-1:0] hi, mbin, med;
  logic [31:0] mcount;
  logic [63:0] prod;
  logic [1:0]  mphase;
  logic        mul_sel_sq;
  logic [31:0] mul_a, mul_b;
  logic        ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_wdata, ram_rdata;
  logic        div_start;
  div_ctl_t    div_ctl;
  logic [31:0] quot;
  logic [31:0] sq_reg;
  logic        req_fire, res_fire;
  logic        res_load;

  assign req_fire = req_valid && !req_stall;
  assign res_fire = res_valid && !res_stall;
  assign req_stall = (state != ST_IDLE);
  // The result register takes a new result when it is empty or being emptied.
  assign res_load = (state == ST_OUT) && (!res_valid || res_fire);

  always_comb begin
    logic [12:0] nb;
    nb = (bins_in_use == 13'd0) ? DEFAULT_BINS : bins_in_use;
    if ({19'd0, nb} > MAX_BINS) begin
      n_act = NBINS;
    end else begin
      n_act = (AW+1)'(nb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bins_in_use <= DEFAULT_BINS;
      bin_div     <= 32'd1;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BINS) begin
        bins_in_use <= cfg_data[12:0];
      end else begin
        bin_div <= cfg_data;
      end
    end
  end

  hse_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.sample),
    .divisor  (bin_div),
    .ctl      (div_ctl),
    .quotient (quot)
  );

  hse_bin_ram #(.MAX_BINS(MAX_BINS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Single shared multiplier: index*index, then index*count, then square*count.
  assign mul_a = mul_sel_sq ? sq_reg : 32'(idx[AW-1:0]);
  assign mul_b = (mphase == 2'd0) ? 32'(idx[AW-1:0]) : cnt;

  always_ff @(posedge clk) begin
    prod <= {32'd0, mul_a} * {32'd0, mul_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_addr   = idx[AW-1:0];
    ram_wdata  = '0;
    div_start  = 1'b0;
    case (state)
      ST_INIT: begin
        ram_we = 1'b1;
        if (idx == NBINS - 1'b1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          case (op_t'(req.op))
            OP_CLEAR: state_next = ST_INIT;
            OP_ADD: begin
              if (bin_div != 32'd0) begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end
            OP_QUERY: state_next = ST_Q_RD;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (div_ctl.done) begin
          if ({1'b0, quot} < {{(32-AW){1'b0}}, n_act}) begin
            state_next = ST_RD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_RD: state_next = ST_WR;
      ST_WR: begin
        ram_we    = (ram_rdata != COUNT_MAX);
        ram_wdata = ram_rdata + 32'd1;
        state_next = ST_IDLE;
      end
      ST_Q_RD: begin
        if (idx == n_act) begin
          state_next = (total != 64'd0) ? ST_M_RD : ST_OUT;
        end else begin
          state_next = ST_Q_ACC;
        end
      end
      ST_Q_ACC: state_next = ST_Q_MUL;
      ST_Q_MUL: begin
        if (mphase == 2'd3) begin
          state_next = ST_Q_RD;
        end
      end
      ST_M_RD:  state_next = ST_M_ACC;
      ST_M_ACC: begin
        if ((cum + {32'd0, ram_rdata}) >= {1'b0, total[63:1]}) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_M_RD;
        end
      end
      ST_OUT: begin
        if (res_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      res_valid <= 1'b0;
      mphase    <= '0;
      mul_sel_sq <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_fire) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          idx <= (idx == NBINS - 1'b1) ? '0 : idx + 1'b1;
        end
        ST_IDLE: begin
          idx <= '0;
          total <= '0;
          wsum <= '0;
          sqsum <= '0;
          cum <= '0;
          lo <= n_act;
          hi <= '0;
          mbin <= '0;
          med <= '0;
          mcount <= '0;
        end
        ST_DIV: begin
          idx <= (AW+1)'(quot);
        end
        ST_Q_ACC: begin
          cnt <= ram_rdata;
          mphase <= 2'd0;
          mul_sel_sq <= 1'b0;
          if (ram_rdata != 32'd0) begin
            if (lo == n_act) begin
              lo <= idx;
            end
            hi <= idx[AW-1:0];
            if (ram_rdata > mcount) begin
              mcount <= ram_rdata;
              mbin   <= idx[AW-1:0];
            end
            total <= total + {32'd0, ram_rdata};
          end
        end
        ST_Q_MUL: begin
          // Phase 0 issues idx*idx; 1 captures it and issues idx*cnt;
          // 2 adds that and issues sq*cnt; 3 adds the square term.
          mphase <= mphase + 2'd1;
          if (mphase == 2'd1) begin
            sq_reg <= prod[31:0];
            mul_sel_sq <= 1'b1;
          end
          if (mphase == 2'd2) begin
            wsum <= wsum + prod;
          end
          if (mphase == 2'd3) begin
            sqsum <= sqsum + prod;
            idx <= idx + 1'b1;
          end
        end
        ST_Q_RD: begin
          if (idx == n_act) begin
            idx <= '0;
          end
        end
        ST_M_ACC: begin
          cum <= cum + {32'd0, ram_rdata};
          med <= idx[AW-1:0];
          idx <= idx + 1'b1;
        end
        ST_OUT: begin
          if (res_load) begin
            res.is_empty     <= (total == 64'd0);
            res.sample_total <= total;
            res.lowest_bin   <= 13'(lo);
            res.highest_bin  <= 12'(hi);
            res.mode_bin     <= 12'(mbin);
            res.mode_count   <= mcount;
            res.median_bin   <= 12'(med);
            res.index_sum    <= wsum;
            res.square_sum   <= sqsum;
          end
        end
        default: ;
      endcase
    end
  end

  a_no_req_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> req_stall)
    else $error("request accepted while sequencer busy");

  a_res_after_out: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside output state");

  a_div_only_add: assert property (@(posedge clk) disable iff (rst)
    div_ctl.done |-> state == ST_DIV)
    else $error("divider finished outside add");

endmodule

`default_nettype wire
